// File: hdl/rrt_pkg.sv
`timescale 1ns / 1ps

package rrt_pkg;

    // default sizing
    localparam int MAX_WINDOW_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // fixed field widths
    localparam int PRICE_W = 32;
    localparam int WLEN_W  = 5;
    localparam int ALPHA_W = 16;
    localparam int PCT_W   = 7;

    // percent scale constants
    localparam int PCT_FULL = 100;
    localparam int PCT_HALF = 50;

    // register indexes
    localparam logic [1:0] REG_WLEN  = 2'd0;
    localparam logic [1:0] REG_ALPHA = 2'd1;
    localparam logic [1:0] REG_THR   = 2'd2;

    // register reset values
    localparam logic [WLEN_W-1:0]  WLEN_RESET  = 5'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd21845;
    localparam int                 THR_RESET   = 3277;

    // direction codes
    localparam logic [1:0] DIR_FLAT = 2'b00;
    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

endpackage

// File: hdl/rrt_ram.sv
`timescale 1ns / 1ps

module rrt_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/rrt_queue.sv
`timescale 1ns / 1ps

module rrt_queue #(
    parameter int WIDTH = 73,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/rrt_front.sv
`timescale 1ns / 1ps

module rrt_front
    import rrt_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int SUM_W      = PRICE_W + $clog2(MAX_WINDOW_DEF)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_price_valid,
    output logic               o_price_ready,
    input  logic [PRICE_W-1:0] i_price,
    input  logic               i_clear,
    input  logic [WLEN_W-1:0]  i_wlen,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output logic               o_job_ok,
    output logic [SUM_W-1:0]   o_job_gain,
    output logic [SUM_W-1:0]   o_job_loss
);

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int ENT_W = PRICE_W + 1;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SUB  = 2'd1;
    localparam logic [1:0] F_ADD  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]         r_state;
    logic [PRICE_W-1:0] r_last;
    logic               r_seeded;
    logic [PTR_W-1:0]   r_ptr;
    logic [LEN_W-1:0]   r_fill;
    logic [SUM_W-1:0]   r_gain;
    logic [SUM_W-1:0]   r_loss;
    logic [ENT_W-1:0]   r_new;
    logic               r_ok;

    logic [LEN_W-1:0]   w_len;
    logic [PRICE_W:0]   w_diff;
    logic [PRICE_W:0]   w_neg;
    logic               w_pos;
    logic [PRICE_W-1:0] w_mag;
    logic               w_accept;
    logic [ENT_W-1:0]   w_old;
    logic [LEN_W-1:0]   n_ptr;

    // effective window length, clamped to 2..MAX_WINDOW
    always_comb begin
        if (i_wlen < WLEN_W'(2)) begin
            w_len = LEN_W'(2);
        end else if (32'(i_wlen) > MAX_WINDOW) begin
            w_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_len = LEN_W'(i_wlen);
        end
    end

    // change as sign and magnitude
    assign w_diff = {1'b0, i_price} - {1'b0, r_last};
    assign w_neg  = ~w_diff + 1'b1;
    assign w_pos  = !w_diff[PRICE_W] && (w_diff != '0);
    assign w_mag  = w_diff[PRICE_W] ? w_neg[PRICE_W-1:0] : w_diff[PRICE_W-1:0];

    assign w_accept      = i_price_valid && o_price_ready;
    assign o_price_ready = (r_state == F_IDLE);
    assign o_job_valid   = (r_state == F_PUSH);
    assign o_job_ok      = r_ok;
    assign o_job_gain    = r_gain;
    assign o_job_loss    = r_loss;

    // next ring position
    assign n_ptr = LEN_W'(r_ptr) + 1'b1;

    // window ring, one entry per change
    rrt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == F_ADD),
        .i_waddr (r_ptr),
        .i_wdata (r_new),
        .i_re    (w_accept),
        .i_raddr (r_ptr),
        .o_rdata (w_old)
    );

    // accept, retire oldest change, add newest, hand off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_last   <= '0;
            r_seeded <= 1'b0;
            r_ptr    <= '0;
            r_fill   <= '0;
            r_gain   <= '0;
            r_loss   <= '0;
            r_ok     <= 1'b0;
        end else if (i_clear) begin
            r_ptr  <= '0;
            r_fill <= '0;
            r_gain <= '0;
            r_loss <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        r_last <= i_price;
                        r_new  <= {w_pos, w_mag};
                        if (!r_seeded) begin
                            r_seeded <= 1'b1;
                            r_ok     <= 1'b0;
                            r_state  <= F_PUSH;
                        end else begin
                            r_state <= F_SUB;
                        end
                    end
                end
                F_SUB: begin
                    if (r_fill >= w_len) begin
                        if (w_old[PRICE_W]) begin
                            r_gain <= r_gain - SUM_W'(w_old[PRICE_W-1:0]);
                        end else begin
                            r_loss <= r_loss - SUM_W'(w_old[PRICE_W-1:0]);
                        end
                    end else begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= F_ADD;
                end
                F_ADD: begin
                    if (r_new[PRICE_W]) begin
                        r_gain <= r_gain + SUM_W'(r_new[PRICE_W-1:0]);
                    end else begin
                        r_loss <= r_loss + SUM_W'(r_new[PRICE_W-1:0]);
                    end
                    r_ptr   <= (n_ptr >= w_len) ? '0 : PTR_W'(n_ptr);
                    r_ok    <= (r_fill >= w_len);
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/rrt_back.sv
`timescale 1ns / 1ps

module rrt_back
    import rrt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SUM_W     = PRICE_W + $clog2(MAX_WINDOW_DEF)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_valid,
    output logic                           o_job_ready,
    input  logic                           i_job_ok,
    input  logic [SUM_W-1:0]               i_job_gain,
    input  logic [SUM_W-1:0]               i_job_loss,
    input  logic [ALPHA_W-1:0]             i_alpha,
    input  logic [FRAC_BITS+PCT_W-1:0]     i_thr,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic                           o_value_valid,
    output logic [FRAC_BITS+PCT_W-1:0]     o_rsi_value,
    output logic signed [FRAC_BITS+PCT_W:0] o_rsi_slope,
    output logic signed [FRAC_BITS+PCT_W:0] o_smoothed_trend,
    output logic signed [1:0]              o_direction
);

    localparam int RSI_W  = FRAC_BITS + PCT_W;
    localparam int TR_W   = RSI_W + 1;
    localparam int NUM_W  = SUM_W + PCT_W;
    localparam int CNT_W  = $clog2(RSI_W);
    localparam int WT_W   = ALPHA_W + 1;
    localparam int PROD_W = TR_W + WT_W + 1;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_DIV   = 3'd1;
    localparam logic [2:0] B_SLOPE = 3'd2;
    localparam logic [2:0] B_MUL   = 3'd3;
    localparam logic [2:0] B_EMA   = 3'd4;
    localparam logic [2:0] B_DIR   = 3'd5;
    localparam logic [2:0] B_OUT   = 3'd6;

    localparam logic [RSI_W-1:0] RSI_FULL = RSI_W'(PCT_FULL) << FRAC_BITS;
    localparam logic [RSI_W-1:0] RSI_HALF = RSI_W'(PCT_HALF) << FRAC_BITS;

    logic [2:0]               r_state;
    logic [SUM_W-1:0]         r_div;
    logic [SUM_W-1:0]         r_rem;
    logic [RSI_W-1:0]         r_low;
    logic [RSI_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_cnt;
    logic [RSI_W-1:0]         r_rsi_now;
    logic signed [TR_W-1:0]   r_slope;
    logic signed [TR_W-1:0]   r_trend;
    logic                     r_warmed;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic                     r_o_vv;
    logic [RSI_W-1:0]         r_o_rsi;
    logic signed [TR_W-1:0]   r_o_slope;
    logic signed [TR_W-1:0]   r_o_trend;
    logic [1:0]               r_o_dir;

    logic [NUM_W-1:0]         w_num;
    logic [SUM_W:0]           w_trial;
    logic [SUM_W:0]           w_sub;
    logic                     w_ge;
    logic [WT_W-1:0]          w_wt;
    logic signed [PROD_W-1:0] w_sum;
    logic signed [TR_W-1:0]   w_thr;

    // dividend 100*G, split into the part below the divisor and the bits to shift in
    assign w_num = NUM_W'(i_job_gain) * NUM_W'(PCT_FULL);

    // one restoring division step
    assign w_trial = {r_rem, r_low[RSI_W-1]};
    assign w_sub   = w_trial - {1'b0, r_div};
    assign w_ge    = !w_sub[SUM_W];

    // average weights and threshold
    assign w_wt  = WT_W'(2 ** ALPHA_W) - WT_W'(i_alpha);
    assign w_sum = r_p1 + r_p2;
    assign w_thr = $signed({1'b0, i_thr});

    assign o_job_ready      = (r_state == B_IDLE);
    assign o_res_valid      = (r_state == B_OUT);
    assign o_value_valid    = r_o_vv;
    assign o_rsi_value      = r_o_rsi;
    assign o_rsi_slope      = r_o_slope;
    assign o_smoothed_trend = r_o_trend;
    assign o_direction      = r_o_dir;

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_div <= i_job_gain + i_job_loss;
                r_rem <= w_num[NUM_W-1:PCT_W];
                r_low <= {w_num[PCT_W-1:0], {FRAC_BITS{1'b0}}};
                r_quo <= RSI_FULL;
                r_cnt <= CNT_W'(RSI_W - 1);
            end
            B_DIV: begin
                r_rem <= w_ge ? w_sub[SUM_W-1:0] : w_trial[SUM_W-1:0];
                r_low <= r_low << 1;
                r_quo <= {r_quo[RSI_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            B_SLOPE: begin
                r_slope <= $signed({1'b0, r_quo}) - $signed({1'b0, r_rsi_now});
            end
            B_MUL: begin
                r_p1 <= PROD_W'($signed({1'b0, i_alpha}) * r_slope);
                r_p2 <= PROD_W'($signed({1'b0, w_wt}) * r_trend);
            end
            default: begin
            end
        endcase
    end

    // sequencer and carried state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_rsi_now <= RSI_HALF;
            r_trend   <= '0;
            r_warmed  <= 1'b0;
            r_o_vv    <= 1'b0;
            r_o_rsi   <= '0;
            r_o_slope <= '0;
            r_o_trend <= '0;
            r_o_dir   <= DIR_FLAT;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        if (!i_job_ok) begin
                            r_o_vv    <= 1'b0;
                            r_o_rsi   <= '0;
                            r_o_slope <= '0;
                            r_o_trend <= '0;
                            r_o_dir   <= DIR_FLAT;
                            r_state   <= B_OUT;
                        end else if (i_job_loss == '0) begin
                            r_state <= B_SLOPE;
                        end else begin
                            r_state <= B_DIV;
                        end
                    end
                end
                B_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= B_SLOPE;
                    end
                end
                B_SLOPE: begin
                    r_rsi_now <= r_quo;
                    r_state   <= B_MUL;
                end
                B_MUL: begin
                    if (!r_warmed) begin
                        r_trend  <= r_slope;
                        r_warmed <= 1'b1;
                        r_state  <= B_DIR;
                    end else begin
                        r_state <= B_EMA;
                    end
                end
                B_EMA: begin
                    // floor of the weighted sum over 2^16
                    r_trend <= w_sum[ALPHA_W+TR_W-1:ALPHA_W];
                    r_state <= B_DIR;
                end
                B_DIR: begin
                    r_o_vv    <= 1'b1;
                    r_o_rsi   <= r_rsi_now;
                    r_o_slope <= r_slope;
                    r_o_trend <= r_trend;
                    if (r_trend > w_thr) begin
                        r_o_dir <= DIR_UP;
                    end else if (r_trend < -w_thr) begin
                        r_o_dir <= DIR_DOWN;
                    end else begin
                        r_o_dir <= DIR_FLAT;
                    end
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (i_res_ready) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/rolling_rsi_trend.sv
`timescale 1ns / 1ps
// path from input beat to result beat: the front's accept, retire and add states, the
// job queue, then FRAC_BITS+7 serial divider steps (none with no losses in the window),
// slope, multiply, average and direction; the front takes a new price only after handing
// off its job; seeding and window-filling beats skip the divider but still give a result
// synchronous active-low reset clears control state, sums, RSI to 50 and registers
// to their defaults; the change ring needs no clearing pass

module rolling_rsi_trend
    import rrt_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_price_valid,
    output logic                              o_price_ready,
    input  logic [PRICE_W-1:0]                i_price,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [((FRAC_BITS + PCT_W > ALPHA_W) ? FRAC_BITS + PCT_W : ALPHA_W)-1:0] i_cfg_data,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic                              o_value_valid,
    output logic [FRAC_BITS+PCT_W-1:0]        o_rsi_value,
    output logic signed [FRAC_BITS+PCT_W:0]   o_rsi_slope,
    output logic signed [FRAC_BITS+PCT_W:0]   o_smoothed_trend,
    output logic signed [1:0]                 o_direction
);

    localparam int RSI_W = FRAC_BITS + PCT_W;
    localparam int SUM_W = PRICE_W + $clog2(MAX_WINDOW);
    localparam int JOB_W = 2 * SUM_W + 1;
    localparam logic [RSI_W-1:0] RSI_FULL = RSI_W'(PCT_FULL) << FRAC_BITS;

    logic [WLEN_W-1:0]  r_wlen;
    logic [ALPHA_W-1:0] r_alpha;
    logic [RSI_W-1:0]   r_thr;

    logic               w_clear;
    logic               w_fj_valid;
    logic               w_fj_ok;
    logic [SUM_W-1:0]   w_fj_gain;
    logic [SUM_W-1:0]   w_fj_loss;
    logic               w_q_full;
    logic               w_q_empty;
    logic [JOB_W-1:0]   w_q_data;
    logic               w_bk_ready;

    assign w_clear = i_cfg_we && (i_cfg_index == REG_WLEN);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= WLEN_RESET;
            r_alpha <= ALPHA_RESET;
            r_thr   <= RSI_W'(THR_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WLEN:  r_wlen  <= i_cfg_data[WLEN_W-1:0];
                REG_ALPHA: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                REG_THR:   r_thr   <= i_cfg_data[RSI_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // window front end
    rrt_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .SUM_W      (SUM_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_price_valid (i_price_valid),
        .o_price_ready (o_price_ready),
        .i_price       (i_price),
        .i_clear       (w_clear),
        .i_wlen        (r_wlen),
        .o_job_valid   (w_fj_valid),
        .i_job_ready   (!w_q_full),
        .o_job_ok      (w_fj_ok),
        .o_job_gain    (w_fj_gain),
        .o_job_loss    (w_fj_loss)
    );

    // job queue between front and back
    rrt_queue #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fj_valid),
        .i_data  ({w_fj_ok, w_fj_gain, w_fj_loss}),
        .o_full  (w_q_full),
        .i_pop   (w_bk_ready),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    // RSI divider, slope average and direction
    rrt_back #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_W     (SUM_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (!w_q_empty),
        .o_job_ready      (w_bk_ready),
        .i_job_ok         (w_q_data[JOB_W-1]),
        .i_job_gain       (w_q_data[2*SUM_W-1:SUM_W]),
        .i_job_loss       (w_q_data[SUM_W-1:0]),
        .i_alpha          (r_alpha),
        .i_thr            (r_thr),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_value_valid    (o_value_valid),
        .o_rsi_value      (o_rsi_value),
        .o_rsi_slope      (o_rsi_slope),
        .o_smoothed_trend (o_smoothed_trend),
        .o_direction      (o_direction)
    );

    // result beats without new values carry zero fields
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_value_valid |->
            o_rsi_value == '0 && o_rsi_slope == '0 && o_smoothed_trend == '0 &&
            o_direction == DIR_FLAT)
        else $error("non-valid result beat carries nonzero fields");

    // RSI never exceeds full scale
    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_rsi_value <= RSI_FULL)
        else $error("rsi above 100 percent");

    // an up direction comes only with a positive smoothed trend
    a_dir_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_direction == DIR_UP |-> o_smoothed_trend > 0)
        else $error("up direction with non-positive trend");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_direction == DIR_UP || o_direction == DIR_DOWN ||
            o_direction == DIR_FLAT)
        else $error("invalid direction code");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rrt_pkg::*;

    localparam int          CFG_W        = FRAC_BITS_DEF + PCT_W;
    localparam int          RANDOM_ITEMS = 1780;
    localparam longint      PRICE_MAX    = 64'h0000_0000_FFFF_FFFF;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;

    // one result beat as the block should deliver it
    typedef struct packed {
        logic        vld;
        logic [22:0] rsi;
        logic [23:0] slope;
        logic [23:0] trend;
        logic [1:0]  dir;
    } t_rsi_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_price_valid;
    logic              o_price_ready;
    logic [31:0]       i_price;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              o_res_valid;
    logic              i_res_ready;
    logic              o_value_valid;
    logic [22:0]       o_rsi_value;
    logic signed [23:0] o_rsi_slope;
    logic signed [23:0] o_smoothed_trend;
    logic signed [1:0] o_direction;

    rolling_rsi_trend dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_price_valid    (i_price_valid),
        .o_price_ready    (o_price_ready),
        .i_price          (i_price),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_value_valid    (o_value_valid),
        .o_rsi_value      (o_rsi_value),
        .o_rsi_slope      (o_rsi_slope),
        .o_smoothed_trend (o_smoothed_trend),
        .o_direction      (o_direction)
    );

    // results still owed by the block, oldest first
    t_rsi_result pending_rsi[$];
    int          mismatch_count = 0;
    bit          fast_mode = 0;
    int          hold_left = 0;

    // shadow copy of the block state and registers
    logic [31:0] prev_price;
    bit          price_seeded;
    longint      change_hist[16];
    int          hist_ptr;
    int          hist_fill;
    longint      gain_sum;
    longint      loss_sum;
    longint      rsi_last;
    longint      trend_ema;
    bit          ema_seeded;
    logic [4:0]  wlen_reg;
    logic [15:0] alpha_reg;
    logic [22:0] thr_reg;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        if (mismatch_count < 100)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // advance the shadow state by one price beat and return the expected result
    function automatic t_rsi_result next_rsi_values(input logic [31:0] p);
        t_rsi_result r;
        int          len;
        longint      chg;
        longint      old;
        longint      rsi_new;
        longint      slope;
        longint      thr;
        r = '0;
        if (!price_seeded) begin
            prev_price   = p;
            price_seeded = 1'b1;
            return r;
        end
        chg = $signed({32'd0, p}) - $signed({32'd0, prev_price});
        prev_price = p;
        len = (wlen_reg < 2) ? 2 : ((wlen_reg > 16) ? 16 : int'(wlen_reg));
        if (hist_ptr >= len) hist_ptr = 0;
        // drop the oldest change once the window is full
        if (hist_fill >= len) begin
            old = change_hist[hist_ptr];
            if (old > 0) gain_sum -= old;
            else loss_sum += old;
            hist_fill = len;
        end else begin
            hist_fill++;
        end
        change_hist[hist_ptr] = chg;
        if (chg > 0) gain_sum += chg;
        else loss_sum -= chg;
        hist_ptr = (hist_ptr + 1 >= len) ? 0 : hist_ptr + 1;
        if (hist_fill < len) return r;
        // truncated percentage in q16, pinned at 100 with no losses
        if (loss_sum == 0) rsi_new = longint'(PCT_FULL) << FRAC_BITS_DEF;
        else rsi_new = (gain_sum * PCT_FULL * 65536) / (gain_sum + loss_sum);
        slope    = rsi_new - rsi_last;
        rsi_last = rsi_new;
        if (!ema_seeded) begin
            trend_ema  = slope;
            ema_seeded = 1'b1;
        end else begin
            trend_ema = (longint'(alpha_reg) * slope
                         + (65536 - longint'(alpha_reg)) * trend_ema) >>> 16;
        end
        thr     = longint'(thr_reg);
        r.vld   = 1'b1;
        r.rsi   = rsi_new[22:0];
        r.slope = slope[23:0];
        r.trend = trend_ema[23:0];
        if (trend_ema > thr) r.dir = DIR_UP;
        else if (trend_ema < -thr) r.dir = DIR_DOWN;
        else r.dir = DIR_FLAT;
        return r;
    endfunction

    // one price beat, with a random gap in front
    task automatic send_price(input logic [31:0] p);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_price_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_price_valid <= 1'b1;
        i_price       <= p;
        do @(posedge i_clk); while (!o_price_ready);
        pending_rsi.insert(pending_rsi.size(), next_rsi_values(p));
    endtask

    // register write, mirrored into the shadow copy
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_WLEN: begin
                wlen_reg  = data[WLEN_W-1:0];
                hist_ptr  = 0;
                hist_fill = 0;
                gain_sum  = 0;
                loss_sum  = 0;
                foreach (change_hist[k]) change_hist[k] = 0;
            end
            REG_ALPHA: alpha_reg = data[ALPHA_W-1:0];
            REG_THR:   thr_reg = data[22:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering beats and let every owed result come out
    task automatic wait_drained;
        i_price_valid <= 1'b0;
        while (pending_rsi.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // result side: check each beat, then stall at random or during a hold-off
    initial begin
        t_rsi_result want;
        int          stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_res_valid && i_res_ready) begin
                if (pending_rsi.size() == 0) begin
                    report("result with nothing outstanding", 0, 0);
                end else begin
                    want = pending_rsi[0];
                    pending_rsi.delete(0);
                    if (o_value_valid !== want.vld)
                        report("value_valid", o_value_valid, want.vld);
                    if (o_rsi_value !== want.rsi)
                        report("rsi_value", o_rsi_value, want.rsi);
                    if (o_rsi_slope !== want.slope)
                        report("slope", o_rsi_slope, $signed(want.slope));
                    if (o_smoothed_trend !== want.trend)
                        report("smoothed_trend", o_smoothed_trend, $signed(want.trend));
                    if (o_direction !== want.dir)
                        report("direction", o_direction, $signed(want.dir));
                end
                stall = fast_mode ? 0 : $urandom_range(0, 5);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_res_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    // default registers, zero seed price, window filling to its first value
    task automatic test_defaults;
        logic [31:0] seq[12];
        seq = '{32'd0, 32'd100, 32'd250, 32'd200, 32'd400, 32'd380,
                32'd500, 32'd450, 32'd700, 32'd650, 32'd800, 32'd780};
        foreach (seq[k]) send_price(seq[k]);
    endtask

    // full-scale swings, flat window, all gains and all losses
    task automatic test_extreme_prices;
        logic [31:0] seq[7];
        seq = '{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'd0, 32'd0};
        wait_drained();
        write_reg(REG_WLEN, {18'h3FFFF, 5'd1});
        write_reg(REG_ALPHA, {7'h7F, 16'hFFFF});
        write_reg(REG_THR, '0);
        foreach (seq[k]) send_price(seq[k]);
    endtask

    // zero smoothing weight, ignored register index, top threshold
    task automatic test_alpha_hold;
        wait_drained();
        write_reg(REG_ALPHA, {7'h55, 16'h0000});
        write_reg(REG_UNUSED, 23'h7FFFFF);
        write_reg(REG_THR, 23'd6553600);
        write_reg(REG_WLEN, {18'h15555, 5'd3});
        send_price(32'd1000);
        send_price(32'd1500);
        send_price(32'd1200);
        send_price(32'd2600);
        send_price(32'd2500);
    endtask

    // long receiver hold-off while the sender keeps pushing, then a full pause
    task automatic test_backpressure;
        wait_drained();
        write_reg(REG_WLEN, 23'd4);
        write_reg(REG_ALPHA, 23'd13107);
        write_reg(REG_THR, 23'd3277);
        fast_mode = 1'b1;
        hold_left = 400;
        for (int k = 0; k < 40; k++) send_price(32'd50000 + $urandom_range(0, 4000));
        fast_mode = 1'b0;
        wait_drained();
    endtask

    // random walks under random settings, with some pure noise beats
    task automatic test_random_walks;
        logic [CFG_W-1:0] cfg;
        logic [31:0]      p;
        longint           level;
        longint           mag;
        int               run_len;
        int               step_bits;
        int               up_pct;
        int               sent;
        sent  = 0;
        level = 32'd1_000_000;
        while (sent < RANDOM_ITEMS) begin
            // new settings only with the block idle
            if ($urandom_range(0, 2) != 0) begin
                wait_drained();
                if ($urandom_range(0, 1) != 0) begin
                    cfg = CFG_W'($urandom());
                    cfg[WLEN_W-1:0] = ($urandom_range(0, 7) == 0)
                                      ? WLEN_W'($urandom_range(0, 31))
                                      : WLEN_W'($urandom_range(2, 16));
                    write_reg(REG_WLEN, cfg);
                end
                cfg = CFG_W'($urandom());
                case ($urandom_range(0, 4))
                    0: cfg[15:0] = 16'd1;
                    1: cfg[15:0] = 16'hFFFF;
                    2: cfg[15:0] = 16'd0;
                    default: ;
                endcase
                write_reg(REG_ALPHA, cfg);
                case ($urandom_range(0, 4))
                    0: cfg = '0;
                    1: cfg = 23'd6553600;
                    2: cfg = CFG_W'($urandom_range(0, 20000));
                    default: cfg = CFG_W'($urandom());
                endcase
                write_reg(REG_THR, cfg);
                if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, CFG_W'($urandom()));
            end
            if ($urandom_range(0, 1) != 0) begin
                case ($urandom_range(0, 3))
                    0: level = 0;
                    1: level = PRICE_MAX;
                    default: level = longint'($urandom());
                endcase
            end
            fast_mode = ($urandom_range(0, 3) == 0);
            run_len   = $urandom_range(8, 60);
            step_bits = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 32)
                                                    : $urandom_range(1, 16);
            up_pct    = $urandom_range(10, 90);
            for (int k = 0; k < run_len; k++) begin
                if ($urandom_range(0, 24) == 0) begin
                    p = $urandom();
                end else begin
                    mag = longint'($urandom()) >> (32 - step_bits);
                    if ($urandom_range(0, 9) == 0) mag = 0;
                    if ($urandom_range(0, 99) < up_pct) level += mag;
                    else level -= mag;
                    if (level < 0) level = 0;
                    if (level > PRICE_MAX) level = PRICE_MAX;
                    p = level[31:0];
                end
                send_price(p);
                sent++;
            end
        end
        fast_mode = 1'b0;
    endtask

    // let the last results out and watch for stray beats
    task automatic test_final_drain;
        int waited;
        i_price_valid <= 1'b0;
        waited = 0;
        while (pending_rsi.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_rsi.size() != 0) report("results never delivered", pending_rsi.size(), 0);
        repeat (50) @(posedge i_clk);
    endtask

    // sequence
    initial begin
        i_rst_n       = 1'b0;
        i_price_valid = 1'b0;
        i_price       = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_WLEN;
        i_cfg_data    = '0;
        i_res_ready   = 1'b0;
        prev_price    = '0;
        price_seeded  = 1'b0;
        foreach (change_hist[k]) change_hist[k] = 0;
        hist_ptr      = 0;
        hist_fill     = 0;
        gain_sum      = 0;
        loss_sum      = 0;
        rsi_last      = (longint'(PCT_FULL) << FRAC_BITS_DEF) / 2;
        trend_ema     = 0;
        ema_seeded    = 1'b0;
        wlen_reg      = WLEN_RESET;
        alpha_reg     = ALPHA_RESET;
        thr_reg       = 23'(THR_RESET);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_extreme_prices();
        test_alpha_hold();
        test_backpressure();
        test_random_walks();
        test_final_drain();

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
